>>> hdl/drd_pkg.sv
// Shared types and constants for the detection row decoder.
package drd_pkg;

    localparam int VAL_W = 32;
    localparam int PIX_W = 16;
    localparam int CLS_W = 8;

    // Configuration register contents
    typedef struct packed {
        logic [16:0] score_threshold;
        logic [7:0]  class_count;
        logic [9:0]  row_length;
        logic [21:0] inverse_scale_x;
        logic [21:0] inverse_scale_y;
        logic [11:0] pad_x;
        logic [11:0] pad_y;
    } t_cfg;

    // One finished row that passed the threshold, raw network values
    typedef struct packed {
        logic [VAL_W-1:0] cx;
        logic [VAL_W-1:0] cy;
        logic [VAL_W-1:0] w;
        logic [VAL_W-1:0] h;
        logic [VAL_W-1:0] score;
        logic [CLS_W-1:0] class_index;
    } t_cand;

endpackage

>>> hdl/drd_regs.sv
// APB configuration register file for the detection row decoder.
module drd_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output drd_pkg::t_cfg o_cfg
);
    import drd_pkg::*;

    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_CLASSES   = 3'd1;
    localparam logic [2:0] REG_ROW_LEN   = 3'd2;
    localparam logic [2:0] REG_SCALE_X   = 3'd3;
    localparam logic [2:0] REG_SCALE_Y   = 3'd4;
    localparam logic [2:0] REG_PAD_X     = 3'd5;
    localparam logic [2:0] REG_PAD_Y     = 3'd6;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.score_threshold <= 17'd16384;
            r_cfg.class_count     <= 8'd80;
            r_cfg.row_length      <= 10'd84;
            r_cfg.inverse_scale_x <= 22'd65536;
            r_cfg.inverse_scale_y <= 22'd65536;
            r_cfg.pad_x           <= 12'd0;
            r_cfg.pad_y           <= 12'd0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_THRESHOLD: r_cfg.score_threshold <= pwdata[16:0];
                REG_CLASSES:   r_cfg.class_count     <= pwdata[7:0];
                REG_ROW_LEN:   r_cfg.row_length      <= pwdata[9:0];
                REG_SCALE_X:   r_cfg.inverse_scale_x <= pwdata[21:0];
                REG_SCALE_Y:   r_cfg.inverse_scale_y <= pwdata[21:0];
                REG_PAD_X:     r_cfg.pad_x           <= pwdata[11:0];
                REG_PAD_Y:     r_cfg.pad_y           <= pwdata[11:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_THRESHOLD: prdata = {15'd0, r_cfg.score_threshold};
            REG_CLASSES:   prdata = {24'd0, r_cfg.class_count};
            REG_ROW_LEN:   prdata = {22'd0, r_cfg.row_length};
            REG_SCALE_X:   prdata = {10'd0, r_cfg.inverse_scale_x};
            REG_SCALE_Y:   prdata = {10'd0, r_cfg.inverse_scale_y};
            REG_PAD_X:     prdata = {20'd0, r_cfg.pad_x};
            REG_PAD_Y:     prdata = {20'd0, r_cfg.pad_y};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

>>> hdl/drd_row.sv
// Row tracker: position count, box capture and running best class score.
module drd_row #(
    parameter int MAX_ROW_LENGTH = 1024,
    parameter int MAX_CLASSES    = 255
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  drd_pkg::t_cfg  i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [31:0]    i_sample_value,
    input  logic           i_row_start,
    output logic           o_cand_valid,
    input  logic           i_cand_ready,
    output drd_pkg::t_cand o_cand
);
    import drd_pkg::*;

    localparam int LEN_CAP = (MAX_ROW_LENGTH < 1023) ? MAX_ROW_LENGTH : 1023;
    localparam int POS_W   = $clog2(LEN_CAP);
    localparam int CLS_CAP = (MAX_CLASSES < 255) ? MAX_CLASSES : 255;
    localparam int CMP_W   = (POS_W > CLS_W) ? POS_W : CLS_W;

    logic [POS_W-1:0]            r_pos;
    logic                        r_seen;
    logic [3:0][VAL_W-1:0]       r_box;
    logic [VAL_W-1:0]            r_best;
    logic [CLS_W-1:0]            r_class;
    logic                        r_cand_valid;
    t_cand                       r_cand;

    logic [POS_W-1:0]            p;
    logic                        seen_in;
    logic [9:0]                  len;
    logic [CLS_W-1:0]            classes;
    logic [10:0]                 p_inc;
    logic                        last;
    logic                        is_box;
    logic                        is_cls;
    logic [CMP_W-1:0]            cls_off;
    logic                        upd;
    logic [POS_W-1:0]            n_pos;
    logic                        n_seen;
    logic [3:0][VAL_W-1:0]       n_box;
    logic [VAL_W-1:0]            n_best;
    logic [CLS_W-1:0]            n_class;
    logic                        emit;
    logic                        accept;

    assign accept       = i_in_valid & o_in_ready;
    assign o_in_ready   = ~r_cand_valid | i_cand_ready;
    assign o_cand_valid = r_cand_valid;
    assign o_cand       = r_cand;

    always_comb begin
        p       = i_row_start ? '0 : r_pos;
        seen_in = (p == '0) ? 1'b0 : r_seen;

        // effective row length: capped, and zero acts as one
        len = (i_cfg.row_length < 10'(LEN_CAP)) ? i_cfg.row_length : 10'(LEN_CAP);
        if (len == 10'd0) begin
            len = 10'd1;
        end
        classes = (i_cfg.class_count < CLS_W'(CLS_CAP)) ? i_cfg.class_count
                                                          : CLS_W'(CLS_CAP);

        is_box  = (p < POS_W'(4));
        cls_off = CMP_W'(p) - CMP_W'(4);
        is_cls  = ~is_box & (cls_off < CMP_W'(classes));
        upd     = is_cls & (~seen_in | ($signed(i_sample_value) > $signed(r_best)));

        n_best  = upd ? i_sample_value : r_best;
        n_class = upd ? cls_off[CLS_W-1:0] : r_class;
        n_seen  = seen_in | is_cls;

        n_box = r_box;
        if (is_box) begin
            n_box[p[1:0]] = i_sample_value;
        end

        p_inc = 11'(p) + 11'd1;
        last  = ~(p_inc < {1'b0, len});
        n_pos = last ? '0 : p_inc[POS_W-1:0];

        emit = last & n_seen &
               ~($signed(n_best) < $signed({15'd0, i_cfg.score_threshold}));
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_seen       <= 1'b0;
            r_cand_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos  <= n_pos;
                r_seen <= n_seen;
            end
            if (accept & emit) begin
                r_cand_valid <= 1'b1;
            end else if (i_cand_ready) begin
                r_cand_valid <= 1'b0;
            end
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_box   <= n_box;
            r_best  <= n_best;
            r_class <= n_class;
        end
        if (accept & emit) begin
            r_cand.cx          <= n_box[0];
            r_cand.cy          <= n_box[1];
            r_cand.w           <= n_box[2];
            r_cand.h           <= n_box[3];
            r_cand.score       <= n_best;
            r_cand.class_index <= n_class;
        end
    end

endmodule

>>> hdl/drd_map.sv
// Box mapping pipeline: padding removal, scaling, rounding and clamping.
module drd_map (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  drd_pkg::t_cfg  i_cfg,
    input  logic           i_cand_valid,
    output logic           o_cand_ready,
    input  drd_pkg::t_cand i_cand,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_class_index,
    output logic [31:0]    o_score,
    output logic [15:0]    o_box_left,
    output logic [15:0]    o_box_top,
    output logic [15:0]    o_box_width,
    output logic [15:0]    o_box_height
);
    import drd_pkg::*;

    localparam logic signed [58:0] ROUND_HALF = 59'sh1_0000_0000;

    // value in units of 2^-33: floor, clamp at zero, saturate
    function automatic logic [PIX_W-1:0] to_pixel(input logic signed [58:0] v);
        logic [PIX_W-1:0] res;
        if (v[58]) begin
            res = '0;
        end else if (|v[57:49]) begin
            res = '1;
        end else begin
            res = v[48:33];
        end
        return res;
    endfunction

    // stage A: offsets
    logic                     r_a_valid;
    logic signed [32:0]       r_a_xo;
    logic signed [32:0]       r_a_yo;
    logic signed [31:0]       r_a_w;
    logic signed [31:0]       r_a_h;
    logic [VAL_W-1:0]         r_a_score;
    logic [CLS_W-1:0]         r_a_cls;
    // stage B: products
    logic                     r_b_valid;
    logic signed [55:0]       r_b_x;
    logic signed [55:0]       r_b_y;
    logic signed [54:0]       r_b_w;
    logic signed [54:0]       r_b_h;
    logic [VAL_W-1:0]         r_b_score;
    logic [CLS_W-1:0]         r_b_cls;
    // stage C: result register
    logic                     r_c_valid;
    logic [PIX_W-1:0]         r_c_left;
    logic [PIX_W-1:0]         r_c_top;
    logic [PIX_W-1:0]         r_c_width;
    logic [PIX_W-1:0]         r_c_height;
    logic [VAL_W-1:0]         r_c_score;
    logic [CLS_W-1:0]         r_c_cls;

    logic                     rdy_a;
    logic                     rdy_b;
    logic                     rdy_c;
    logic signed [32:0]       n_xo;
    logic signed [32:0]       n_yo;
    logic signed [22:0]       scale_x;
    logic signed [22:0]       scale_y;
    logic signed [58:0]       sx;
    logic signed [58:0]       sy;
    logic signed [58:0]       sw;
    logic signed [58:0]       sh;
    logic signed [58:0]       n_left;
    logic signed [58:0]       n_top;
    logic signed [58:0]       n_width;
    logic signed [58:0]       n_height;

    assign rdy_c        = ~r_c_valid | i_out_ready;
    assign rdy_b        = ~r_b_valid | rdy_c;
    assign rdy_a        = ~r_a_valid | rdy_b;
    assign o_cand_ready = rdy_a;

    assign scale_x = $signed({1'b0, i_cfg.inverse_scale_x});
    assign scale_y = $signed({1'b0, i_cfg.inverse_scale_y});

    always_comb begin
        n_xo = $signed({i_cand.cx[31], i_cand.cx}) - $signed({5'd0, i_cfg.pad_x, 16'd0});
        n_yo = $signed({i_cand.cy[31], i_cand.cy}) - $signed({5'd0, i_cfg.pad_y, 16'd0});

        sx = $signed({{3{r_b_x[55]}}, r_b_x});
        sy = $signed({{3{r_b_y[55]}}, r_b_y});
        sw = $signed({{4{r_b_w[54]}}, r_b_w});
        sh = $signed({{4{r_b_h[54]}}, r_b_h});

        n_left   = (sx <<< 1) - sw + ROUND_HALF;
        n_top    = (sy <<< 1) - sh + ROUND_HALF;
        n_width  = (sw <<< 1) + ROUND_HALF;
        n_height = (sh <<< 1) + ROUND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_a_valid <= i_cand_valid;
            end
            if (rdy_b) begin
                r_b_valid <= r_a_valid;
            end
            if (rdy_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a & i_cand_valid) begin
            r_a_xo    <= n_xo;
            r_a_yo    <= n_yo;
            r_a_w     <= $signed(i_cand.w);
            r_a_h     <= $signed(i_cand.h);
            r_a_score <= i_cand.score;
            r_a_cls   <= i_cand.class_index;
        end
        if (rdy_b & r_a_valid) begin
            r_b_x     <= r_a_xo * scale_x;
            r_b_y     <= r_a_yo * scale_y;
            r_b_w     <= r_a_w * scale_x;
            r_b_h     <= r_a_h * scale_y;
            r_b_score <= r_a_score;
            r_b_cls   <= r_a_cls;
        end
        if (rdy_c & r_b_valid) begin
            r_c_left   <= to_pixel(n_left);
            r_c_top    <= to_pixel(n_top);
            r_c_width  <= to_pixel(n_width);
            r_c_height <= to_pixel(n_height);
            r_c_score  <= r_b_score;
            r_c_cls    <= r_b_cls;
        end
    end

    assign o_out_valid   = r_c_valid;
    assign o_class_index = r_c_cls;
    assign o_score       = r_c_score;
    assign o_box_left    = r_c_left;
    assign o_box_top     = r_c_top;
    assign o_box_width   = r_c_width;
    assign o_box_height  = r_c_height;

endmodule

>>> hdl/detection_row_decode.sv
// A row's result passes the candidate register, then the offset, product and
// result stages. Throughput: one row value per cycle (set by the per-value
// compare loop in the row tracker) unless the candidate register is full and
// blocked; results can be drained one per cycle. Reset (synchronous, active
// low) restores the register defaults, clears the row position and empties
// the result pipeline; no clearing pass is needed. Top level of the decoder.
module detection_row_decode #(
    parameter int MAX_ROW_LENGTH = 1024,
    parameter int MAX_CLASSES    = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // value request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_sample_value,
    input  logic        i_row_start,
    // detection request channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_class_index,
    output logic [31:0] o_score,
    output logic [15:0] o_box_left,
    output logic [15:0] o_box_top,
    output logic [15:0] o_box_width,
    output logic [15:0] o_box_height
);
    import drd_pkg::*;

    t_cfg  cfg;
    t_cand cand;
    logic  cand_valid;
    logic  cand_ready;

    // Register file: writes land in the access phase, reads are combinational.
    drd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Row tracker: advance the position on every accepted value, keep the
    // box and the first maximal class score, and hold a candidate register
    // loaded at row end when the best score meets the threshold. It stalls
    // the input only while that candidate register is full and blocked.
    drd_row #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_CLASSES    (MAX_CLASSES)
    ) u_row (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_value (i_sample_value),
        .i_row_start    (i_row_start),
        .o_cand_valid   (cand_valid),
        .i_cand_ready   (cand_ready),
        .o_cand         (cand)
    );

    // Mapping pipeline: drop padding, scale by the reciprocal factors, then
    // round, clamp at zero and saturate into the output register. Each stage
    // holds its contents while the next one is blocked.
    drd_map u_map (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cand_valid  (cand_valid),
        .o_cand_ready  (cand_ready),
        .i_cand        (cand),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_class_index (o_class_index),
        .o_score       (o_score),
        .o_box_left    (o_box_left),
        .o_box_top     (o_box_top),
        .o_box_width   (o_box_width),
        .o_box_height  (o_box_height)
    );

endmodule

>>> bench/testbench.sv
// Self-checking bench for the detection row decoder: value stream in, detections out.
module testbench;
    import drd_pkg::*;

    // Row length and class count caps of the block as built
    localparam int MAX_ROW_LENGTH = 1024;
    localparam int MAX_CLASSES    = 255;
    // A detection comes out through the candidate register and the mapping stages; leave margin
    localparam int DRAIN_CYCLES   = 10;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int RANDOM_VALUES  = 360;
    // One half pixel in units of 2^-33, used when rounding box edges
    localparam longint ROUND_HALF = 64'sd1 <<< 32;

    // Register indexes; byte address is four times the index
    typedef enum int {
        REG_THRESHOLD   = 0,
        REG_CLASS_COUNT = 1,
        REG_ROW_LENGTH  = 2,
        REG_INV_SCALE_X = 3,
        REG_INV_SCALE_Y = 4,
        REG_PAD_X       = 5,
        REG_PAD_Y       = 6
    } t_reg;

    typedef struct packed {
        logic [CLS_W-1:0] class_index;
        logic [VAL_W-1:0] score;
        logic [PIX_W-1:0] box_left;
        logic [PIX_W-1:0] box_top;
        logic [PIX_W-1:0] box_width;
        logic [PIX_W-1:0] box_height;
    } t_detection;

    // Tracks the row decode state and holds the detections still owed by the block
    class detection_tracker;
        longint score_threshold, class_count, row_length;
        longint inverse_scale_x, inverse_scale_y, pad_x, pad_y;
        int unsigned position;
        longint box_value[4];
        longint best_score;
        int unsigned best_class;
        bit score_seen;
        t_detection due[$];
        int errors;

        function new();
            score_threshold = 16384;
            class_count = 80;
            row_length = 84;
            inverse_scale_x = 65536;
            inverse_scale_y = 65536;
            pad_x = 0;
            pad_y = 0;
            position = 0;
            foreach (box_value[i]) box_value[i] = 0;
            best_score = 0;
            best_class = 0;
            score_seen = 1'b0;
            errors = 0;
        endfunction

        function void set_register(t_reg which, logic [31:0] value);
            case (which)
                REG_THRESHOLD:   score_threshold = longint'(value[16:0]);
                REG_CLASS_COUNT: class_count = longint'(value[7:0]);
                REG_ROW_LENGTH:  row_length = longint'(value[9:0]);
                REG_INV_SCALE_X: inverse_scale_x = longint'(value[21:0]);
                REG_INV_SCALE_Y: inverse_scale_y = longint'(value[21:0]);
                REG_PAD_X:       pad_x = longint'(value[11:0]);
                REG_PAD_Y:       pad_y = longint'(value[11:0]);
                default: ;
            endcase
        endfunction

        // v in units of 2^-33: floor, clamp at zero, saturate to 16 bits
        function logic [15:0] to_pixel(longint v);
            if (v < 0) return 16'd0;
            v = v >>> 33;
            return (v > 65535) ? 16'hFFFF : v[15:0];
        endfunction

        function void take_value(logic [31:0] raw, logic start);
            longint v, x, y, w, h;
            int unsigned p, len, classes;
            t_detection d;
            v = longint'($signed(raw));
            if (start) position = 0;
            p = position;
            if (p == 0) score_seen = 1'b0;
            len = (row_length < MAX_ROW_LENGTH) ? int'(row_length) : MAX_ROW_LENGTH;
            if (len == 0) len = 1;
            classes = (class_count < MAX_CLASSES) ? int'(class_count) : MAX_CLASSES;
            if (p < 4) begin
                box_value[p] = v;
            end else if (p - 4 < classes) begin
                // first maximum wins, later ties do not replace it
                if (!score_seen || v > best_score) begin
                    best_score = v;
                    best_class = p - 4;
                end
                score_seen = 1'b1;
            end
            if (p + 1 < len) begin
                position = p + 1;
                return;
            end
            position = 0;
            if (!score_seen || best_score < score_threshold) return;
            x = (box_value[0] - pad_x * 65536) * inverse_scale_x;
            y = (box_value[1] - pad_y * 65536) * inverse_scale_y;
            w = box_value[2] * inverse_scale_x;
            h = box_value[3] * inverse_scale_y;
            d.class_index = best_class[7:0];
            d.score = best_score[31:0];
            d.box_left = to_pixel(2 * x - w + ROUND_HALF);
            d.box_top = to_pixel(2 * y - h + ROUND_HALF);
            d.box_width = to_pixel(2 * w + ROUND_HALF);
            d.box_height = to_pixel(2 * h + ROUND_HALF);
            due = {due, d};
        endfunction

        task report_mismatch(string what, longint got_v, longint want_v);
            $display("mismatch %s: got %0h expected %0h", what, got_v, want_v);
            errors++;
        endtask

        task check_detection(t_detection got);
            t_detection want;
            if (due.size() == 0) begin
                report_mismatch("detection with none due, class",
                                longint'(got.class_index), longint'(0));
                return;
            end
            want = due.pop_front();
            if (got.class_index != want.class_index)
                report_mismatch("class_index", longint'(got.class_index),
                                longint'(want.class_index));
            if (got.score != want.score)
                report_mismatch("score", longint'(got.score), longint'(want.score));
            if (got.box_left != want.box_left)
                report_mismatch("box_left", longint'(got.box_left),
                                longint'(want.box_left));
            if (got.box_top != want.box_top)
                report_mismatch("box_top", longint'(got.box_top), longint'(want.box_top));
            if (got.box_width != want.box_width)
                report_mismatch("box_width", longint'(got.box_width),
                                longint'(want.box_width));
            if (got.box_height != want.box_height)
                report_mismatch("box_height", longint'(got.box_height),
                                longint'(want.box_height));
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [4:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [VAL_W-1:0] i_sample_value = '0;
    logic             i_row_start = 1'b0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [CLS_W-1:0] o_class_index;
    logic [VAL_W-1:0] o_score;
    logic [PIX_W-1:0] o_box_left;
    logic [PIX_W-1:0] o_box_top;
    logic [PIX_W-1:0] o_box_width;
    logic [PIX_W-1:0] o_box_height;

    detection_tracker tracker;
    int  tx_idle = 38;      // percent of cycles the value sender holds off
    int  rx_idle = 71;      // percent of cycles the detection side stalls
    int  values_sent = 0;
    int  cycle_count = 0;
    bit  need_start = 1'b1;

    detection_row_decode dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_value (i_sample_value),
        .i_row_start    (i_row_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_class_index  (o_class_index),
        .o_score        (o_score),
        .o_box_left     (o_box_left),
        .o_box_top      (o_box_top),
        .o_box_width    (o_box_width),
        .o_box_height   (o_box_height)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stall the detection side at random, per the current idle percentage
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= rx_idle);
    end

    // Check every detection request taken at this edge against the oldest one due
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_detection(t_detection'{o_class_index, o_score, o_box_left,
                                                 o_box_top, o_box_width, o_box_height});
    end

    // Hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [31:0] q16(int whole);
        return 32'(whole * 65536);
    endfunction

    // Write one register: setup cycle, access cycle, then release the bus
    task automatic apb_write(t_reg which, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(int'(which) * 4);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        tracker.set_register(which, value);
        @(posedge i_clk);
    endtask

    task automatic configure(logic [16:0] threshold, logic [7:0] classes, logic [9:0] len,
                             logic [21:0] scale_x, logic [21:0] scale_y,
                             logic [11:0] offset_x, logic [11:0] offset_y);
        apb_write(REG_THRESHOLD, 32'(threshold));
        apb_write(REG_CLASS_COUNT, 32'(classes));
        apb_write(REG_ROW_LENGTH, 32'(len));
        apb_write(REG_INV_SCALE_X, 32'(scale_x));
        apb_write(REG_INV_SCALE_Y, 32'(scale_y));
        apb_write(REG_PAD_X, 32'(offset_x));
        apb_write(REG_PAD_Y, 32'(offset_y));
    endtask

    // Drop valid and hold until every owed detection has come out, plus latency
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Offer one value request, after an optional random hold-off
    task automatic send_value(logic [31:0] value, logic start);
        if ($urandom_range(0, 99) < tx_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle);
        end
        i_in_valid <= 1'b1;
        i_sample_value <= value;
        i_row_start <= start;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.take_value(value, start);
        values_sent++;
    endtask

    // Plausible content for a row position: centres, sizes, scores, trailing values
    function automatic logic [31:0] row_value(int pos, logic [31:0] prev_score);
        int r;
        r = $urandom_range(0, 99);
        if (pos < 2) begin
            if (r < 90) return ($urandom_range(0, 1500) << 16) | $urandom_range(0, 65535);
            return $urandom();
        end
        if (pos < 4) begin
            if (r < 85) return $urandom_range(0, 600 << 16);
            if (r < 95) return -$urandom_range(0, 600 << 16);
            return $urandom();
        end
        if (pos - 4 < tracker.class_count) begin
            if (pos > 4 && r < 10) return prev_score;
            if (r < 70) return $urandom_range(0, 32'h18000);
            if (r < 85) return -$urandom_range(0, 32'h18000);
            return $urandom();
        end
        return $urandom();
    endfunction

    task automatic send_row_values(int count);
        logic [31:0] value;
        logic [31:0] prev_score;
        logic        start;
        int          pos;
        prev_score = '0;
        for (pos = 0; pos < count; pos++) begin
            value = row_value(pos, prev_score);
            if (pos >= 4) prev_score = value;
            // position is already zero here, so the flag is optional unless forced
            start = (pos == 0) && (need_start || $urandom_range(0, 3) != 0);
            send_value(value, start);
        end
        need_start = 1'b0;
    endtask

    // Mostly whole rows; some cut short, some plain noise with stray row starts
    task automatic send_random_row();
        int n, kind;
        n = (tracker.row_length == 0) ? 1 : int'(tracker.row_length);
        kind = $urandom_range(0, 99);
        if (kind < 78) begin
            send_row_values(n);
        end else if (kind < 90) begin
            send_row_values($urandom_range(1, n));
            need_start = 1'b1;
        end else begin
            repeat ($urandom_range(1, 6))
                send_value($urandom(), $urandom_range(0, 7) == 0);
            need_start = 1'b1;
        end
    endtask

    task automatic configure_random();
        logic [16:0] threshold;
        logic [21:0] scale_x, scale_y;
        logic [11:0] offset_x, offset_y;
        int classes, len, r;
        r = $urandom_range(0, 9);
        threshold = (r == 0) ? 17'd0 : (r == 1) ? 17'd65536 :
                    (r == 2) ? 17'($urandom_range(65537, 131071)) :
                    17'($urandom_range(0, 65536));
        r = $urandom_range(0, 19);
        classes = (r == 0) ? 0 : (r == 1) ? 255 : (r == 2) ? $urandom_range(11, 254) :
                  $urandom_range(1, 10);
        r = $urandom_range(0, 9);
        if (r == 0) len = $urandom_range(0, 4);
        else if (r == 1) len = $urandom_range(5, 40);
        else len = 4 + classes + $urandom_range(0, 3);
        if (len > 1023) len = 1023;
        r = $urandom_range(0, 9);
        scale_x = (r == 0) ? 22'd0 : (r == 1) ? 22'h3FFFFF : 22'($urandom_range(16384, 262144));
        r = $urandom_range(0, 9);
        scale_y = (r == 0) ? 22'd0 : (r == 1) ? 22'h3FFFFF : 22'($urandom_range(16384, 262144));
        offset_x = ($urandom_range(0, 9) == 0) ? 12'hFFF : 12'($urandom_range(0, 100));
        offset_y = ($urandom_range(0, 9) == 0) ? 12'hFFF : 12'($urandom_range(0, 100));
        configure(threshold, 8'(classes), 10'(len), scale_x, scale_y, offset_x, offset_y);
    endtask

    initial begin
        int base_values, rows, sent;
        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: tie on the best score, negative height, trailing value
        configure(17'd16384, 8'd2, 10'd7, 22'd65536, 22'd65536, 12'd0, 12'd0);
        send_value(q16(100) + 32'h8000, 1'b1);
        send_value(q16(50), 1'b0);
        send_value(q16(20), 1'b0);
        send_value(q16(-10), 1'b0);
        send_value(32'h0000_8000, 1'b0);
        send_value(32'h0000_8000, 1'b0);
        send_value(32'h0000_0001, 1'b0);
        // Drop a partial row with a fresh row start; then full-scale values everywhere
        send_value(q16(7), 1'b1);
        send_value(32'h7FFF_FFFF, 1'b1);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'h7FFF_FFFF, 1'b0);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'h7FFF_FFFF, 1'b0);
        send_value(32'hFFFF_FFFF, 1'b0);

        // Class count running past the row end, score equal to a zero threshold,
        // extreme scales and padding
        drain();
        configure(17'd0, 8'd5, 10'd5, 22'h3FFFFF, 22'd0, 12'hFFF, 12'hFFF);
        send_value(q16(10), 1'b1);
        send_value(q16(10), 1'b0);
        send_value(q16(3), 1'b0);
        send_value(q16(3), 1'b0);
        send_value(32'h0000_0000, 1'b0);

        // Zero row length: every value is a row of its own, no score, no detection
        drain();
        apb_write(REG_ROW_LENGTH, 32'd0);
        send_value(q16(1), 1'b1);

        // No classes at all
        drain();
        apb_write(REG_CLASS_COUNT, 32'd0);
        apb_write(REG_ROW_LENGTH, 32'd5);
        repeat (5) send_value($urandom(), 1'b0);

        // Shorten the row while one is open: the next value closes it
        drain();
        configure(17'd65536, 8'd3, 10'd10, 22'd65536, 22'd98304, 12'd16, 12'd8);
        send_value(q16(40), 1'b1);
        send_value(q16(30), 1'b0);
        send_value(q16(12), 1'b0);
        send_value(q16(6), 1'b0);
        send_value(q16(1), 1'b0);
        drain();
        apb_write(REG_ROW_LENGTH, 32'd5);
        send_value(q16(2), 1'b0);

        // Random part: reconfigure every few rows, shifting the idle mix by thirds
        drain();
        configure_random();
        base_values = values_sent;
        rows = 0;
        sent = 0;
        while (sent < RANDOM_VALUES) begin
            if (sent < RANDOM_VALUES / 3) begin
                tx_idle = 38;
                rx_idle = 71;
            end else if (sent < 2 * RANDOM_VALUES / 3) begin
                tx_idle = 71;
                rx_idle = 38;
            end else begin
                tx_idle = 0;
                rx_idle = 0;
            end
            // hold the sender until the owed detections are out, then retune
            if (rows == 8) begin
                drain();
                configure_random();
                rows = 0;
            end
            send_random_row();
            rows++;
            sent = values_sent - base_values;
        end

        // One long row at the largest class count, with trailing values
        drain();
        configure(17'd0, 8'd255, 10'd300, 22'd65536, 22'd65536, 12'd0, 12'd0);
        need_start = 1'b1;
        send_row_values(300);

        drain();
        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
hdl/drd_pkg.sv
hdl/drd_regs.sv
hdl/drd_row.sv
hdl/drd_map.sv
hdl/detection_row_decode.sv
bench/testbench.sv
